@@ design/hle_pkg.sv @@
`timescale 1ns / 1ps
// Package for the href link extractor: field widths, register indexes,
// pattern table, page limits and the result word type. No dependencies.
package hle_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 10;
    localparam int COUNT_W = 11;
    localparam int INDEX_W = 10;

    localparam int URL_LEN_MAX   = 1024;
    localparam int URL_COUNT_MAX = 1024;

    localparam int CFG_DATA_W = COUNT_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_URL_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_URLS    = 1'b1;

    localparam logic [LEN_W-1:0]   MAX_URL_LEN_RESET = 10'd1000;
    localparam logic [COUNT_W-1:0] MAX_URLS_RESET    = 11'd1000;

    localparam int LEN_ALL   = (1 << LEN_W) - 1;
    localparam int COUNT_ALL = (1 << COUNT_W) - 1;
    localparam logic [LEN_W-1:0] LEN_CAP =
        LEN_W'((URL_LEN_MAX > LEN_ALL) ? LEN_ALL : URL_LEN_MAX);
    localparam logic [COUNT_W-1:0] COUNT_CAP =
        COUNT_W'((URL_COUNT_MAX > COUNT_ALL) ? COUNT_ALL : URL_COUNT_MAX);

    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_H     = 8'h68;
    localparam logic [2:0]        PAT_LAST = 3'd6;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               url_end;
        logic [INDEX_W-1:0] url_index;
        logic               url_truncated;
        logic               run_last;
    } result_t;

    // Bytes of "a href=" by match position.
    function automatic logic [BYTE_W-1:0] pattern_byte(input logic [2:0] pos);
        logic [BYTE_W-1:0] ch;
        case (pos)
            3'd0:    ch = 8'h61;
            3'd1:    ch = 8'h20;
            3'd2:    ch = 8'h68;
            3'd3:    ch = 8'h72;
            3'd4:    ch = 8'h65;
            3'd5:    ch = 8'h66;
            3'd6:    ch = 8'h3d;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ design/href_link_extractor_top.sv @@
`timescale 1ns / 1ps
// Top level of the href link extractor: pattern parser and output queue.
// Depends on hle_pkg.
//
// Usage: page bytes enter on the s_axis channel, one word per byte, with
// s_axis_tlast marking the last byte of a page. Link bytes and end markers
// leave on the m_axis channel; m_axis_tlast marks the last word caused by
// one input byte, and m_axis_tuser tells a link byte from an end marker.
// The two limits are written through cfg_we, cfg_index and cfg_wdata
// while the block is idle.
// Results are registered in the output queue before they reach m_axis.
// Throughput: one byte per cycle while s_axis_tready is high. The parser
// state updates in the cycle a byte is taken, and its results go into a
// four-word output queue. A byte that causes two words (a page end inside
// a link) writes both into the queue at once.
// Stall: s_axis_tready stays high while the queue has room for two words,
// so the input keeps running after m_axis_tready drops until that room is gone.
// Reset: the parser returns to pattern search, counts clear, the queue
// empties and both limits return to 1000.
module href_link_extractor_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [hle_pkg::BYTE_W-1:0]    s_axis_tdata,  // in_byte
    input  logic                          s_axis_tlast,  // page_end
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [hle_pkg::M_TDATA_W-1:0] m_axis_tdata,  // out_byte, url_index, zero pad
    output logic [hle_pkg::M_TUSER_W-1:0] m_axis_tuser,  // url_end, url_truncated
    output logic                          m_axis_tlast,  // run_last
    input  logic                          cfg_we,
    input  logic [hle_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hle_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import hle_pkg::*;

    typedef enum logic [1:0] {
        PH_MATCH,
        PH_QUOTE,
        PH_H,
        PH_URL
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [2:0]         match_pos_reg, match_pos_next;
    logic [LEN_W-1:0]   url_len_reg, url_len_next;
    logic               trunc_seen_reg, trunc_seen_next;
    logic [COUNT_W-1:0] url_count_reg, url_count_next;
    logic               url_live_reg, url_live_next;
    logic [LEN_W-1:0]   max_url_len_reg;
    logic [COUNT_W-1:0] max_urls_reg;

    result_t            queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  rd_ptr_reg, wr_ptr_reg;
    logic [QPTR_W:0]    fill_reg, fill_next;

    logic               accept, pop;
    logic [LEN_W-1:0]   len_lim;
    logic [COUNT_W-1:0] cnt_lim;
    logic [INDEX_W-1:0] cur_index;
    logic               emit_byte, emit_end, emit_close;
    logic               end_trunc;
    result_t            res_first, res_second;
    logic [1:0]         push_n;
    logic [BYTE_W-1:0]  in_b;
    result_t            head;

    assign in_b    = s_axis_tdata;
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign pop     = m_axis_tvalid && m_axis_tready;
    assign len_lim = (max_url_len_reg < LEN_CAP) ? max_url_len_reg : LEN_CAP;
    assign cnt_lim = (max_urls_reg < COUNT_CAP) ? max_urls_reg : COUNT_CAP;

    always_comb
    begin
        phase_next      = phase_reg;
        match_pos_next  = match_pos_reg;
        url_len_next    = url_len_reg;
        trunc_seen_next = trunc_seen_reg;
        url_count_next  = url_count_reg;
        url_live_next   = url_live_reg;
        emit_byte       = 1'b0;
        emit_end        = 1'b0;
        end_trunc       = 1'b0;
        case (phase_reg)
            PH_MATCH:
            begin
                if (match_pos_reg <= PAT_LAST && in_b == pattern_byte(match_pos_reg))
                begin
                    if (match_pos_reg == PAT_LAST)
                    begin
                        match_pos_next = 3'd0;
                        phase_next     = PH_QUOTE;
                    end
                    else
                    begin
                        match_pos_next = match_pos_reg + 3'd1;
                    end
                end
                else
                begin
                    match_pos_next = 3'd0;
                end
            end
            PH_QUOTE:
            begin
                phase_next     = (in_b == CH_QUOTE) ? PH_H : PH_MATCH;
                match_pos_next = 3'd0;
            end
            PH_H:
            begin
                match_pos_next = 3'd0;
                if (in_b != CH_H)
                begin
                    phase_next = PH_MATCH;
                end
                else
                begin
                    phase_next      = PH_URL;
                    url_len_next    = '0;
                    trunc_seen_next = 1'b0;
                    url_live_next   = url_count_reg < cnt_lim;
                    if (url_count_reg < cnt_lim)
                    begin
                        url_count_next = url_count_reg + 11'd1;
                        if (len_lim != '0)
                        begin
                            url_len_next = 10'd1;
                            emit_byte    = 1'b1;
                        end
                        else
                        begin
                            trunc_seen_next = 1'b1;
                        end
                    end
                end
            end
            PH_URL:
            begin
                if (in_b == CH_QUOTE)
                begin
                    emit_end       = url_live_reg;
                    end_trunc      = trunc_seen_reg;
                    phase_next     = PH_MATCH;
                    match_pos_next = 3'd0;
                    url_live_next  = 1'b0;
                end
                else if (url_live_reg)
                begin
                    if (url_len_reg < len_lim)
                    begin
                        url_len_next = url_len_reg + 10'd1;
                        emit_byte    = 1'b1;
                    end
                    else
                    begin
                        trunc_seen_next = 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = PH_MATCH;
            end
        endcase
    end

    assign cur_index  = INDEX_W'(url_count_next - 11'd1);
    assign emit_close = s_axis_tlast && phase_next == PH_URL && url_live_next;

    always_comb
    begin
        res_first  = '0;
        res_second = '0;
        push_n     = 2'd0;
        if (emit_byte || emit_end)
        begin
            res_first.out_byte      = emit_byte ? in_b : '0;
            res_first.url_end       = emit_end;
            res_first.url_index     = cur_index;
            res_first.url_truncated = emit_end && end_trunc;
            res_first.run_last      = !emit_close;
            push_n                  = 2'd1;
            if (emit_close)
            begin
                res_second.url_end       = 1'b1;
                res_second.url_index     = cur_index;
                res_second.url_truncated = trunc_seen_next;
                res_second.run_last      = 1'b1;
                push_n                   = 2'd2;
            end
        end
        else if (emit_close)
        begin
            res_first.url_end       = 1'b1;
            res_first.url_index     = cur_index;
            res_first.url_truncated = trunc_seen_next;
            res_first.run_last      = 1'b1;
            push_n                  = 2'd1;
        end
        if (!accept)
        begin
            push_n = 2'd0;
        end
    end

    assign fill_next = fill_reg + (QPTR_W + 1)'(push_n) - (QPTR_W + 1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_MATCH;
            match_pos_reg   <= '0;
            url_len_reg     <= '0;
            trunc_seen_reg  <= 1'b0;
            url_count_reg   <= '0;
            url_live_reg    <= 1'b0;
            max_url_len_reg <= MAX_URL_LEN_RESET;
            max_urls_reg    <= MAX_URLS_RESET;
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            fill_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_URL_LEN: max_url_len_reg <= cfg_wdata[LEN_W-1:0];
                    REG_MAX_URLS:    max_urls_reg    <= cfg_wdata[COUNT_W-1:0];
                    default:         max_urls_reg    <= max_urls_reg;
                endcase
            end
            if (accept)
            begin
                if (s_axis_tlast)
                begin
                    phase_reg      <= PH_MATCH;
                    match_pos_reg  <= '0;
                    url_len_reg    <= '0;
                    trunc_seen_reg <= 1'b0;
                    url_count_reg  <= '0;
                    url_live_reg   <= 1'b0;
                end
                else
                begin
                    phase_reg      <= phase_next;
                    match_pos_reg  <= match_pos_next;
                    url_len_reg    <= url_len_next;
                    trunc_seen_reg <= trunc_seen_next;
                    url_count_reg  <= url_count_next;
                    url_live_reg   <= url_live_next;
                end
            end
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_n);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res_first;
        end
        if (push_n == 2'd2)
        begin
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= res_second;
        end
    end

    assign head          = queue_reg[rd_ptr_reg];
    assign s_axis_tready = fill_reg <= (QPTR_W + 1)'(QUEUE_DEPTH - 2);
    assign m_axis_tvalid = fill_reg != '0;
    assign m_axis_tdata  = {(M_TDATA_W - BYTE_W - INDEX_W)'(0), head.url_index, head.out_byte};
    assign m_axis_tuser  = {head.url_truncated, head.url_end};
    assign m_axis_tlast  = head.run_last;

endmodule

@@ design/hle_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the href link extractor, with its bind statement.
// Depends on hle_pkg and href_link_extractor_top.
module hle_port_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [hle_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic [hle_pkg::M_TUSER_W-1:0] m_axis_tuser,
    input  logic                          m_axis_tlast
);
    import hle_pkg::*;

    // A stalled output word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // An end marker carries no byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[BYTE_W-1:0] == '0)
        else $error("end marker with a nonzero byte");

    // Only an end marker can report truncation.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> !m_axis_tuser[1])
        else $error("link byte flagged as truncated");

endmodule

bind href_link_extractor_top hle_port_checker u_hle_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ dv/hle_checker.sv @@
`timescale 1ns / 1ps
// Checker for the href link extractor: watches the byte input, output and register write ports,
// predicts every output word and compares it with what the block sends. Depends on hle_pkg.
module hle_checker
    import hle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,
    input  logic                  s_axis_tlast,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [M_TDATA_W-1:0]  m_axis_tdata,
    input  logic [M_TUSER_W-1:0]  m_axis_tuser,
    input  logic                  m_axis_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    expected_left
);

    typedef enum logic [1:0] {SEEK_PATTERN, SEEK_QUOTE, SEEK_H, IN_URL} parse_phase_t;

    localparam logic [55:0] LINK_PATTERN = "a href=";

    parse_phase_t      phase;
    logic [2:0]        pat_pos;
    int                url_bytes;
    logic              dropped;
    int                links_taken;
    logic              link_live;
    logic [LEN_W-1:0]  len_reg;
    logic [COUNT_W-1:0] urls_reg;
    result_t           url_words[$];

    function automatic result_t url_word(logic [BYTE_W-1:0] b, logic is_end, logic trunc);
        result_t w;
        w.out_byte      = b;
        w.url_end       = is_end;
        w.url_index     = INDEX_W'(links_taken - 1);
        w.url_truncated = trunc;
        w.run_last      = 1'b0;
        return w;
    endfunction

    task automatic clear_page();
        phase       = SEEK_PATTERN;
        pat_pos     = 3'd0;
        url_bytes   = 0;
        dropped     = 1'b0;
        links_taken = 0;
        link_live   = 1'b0;
    endtask

    task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic page_last);
        result_t words[2];
        int      n;
        int      len_lim;
        int      cnt_lim;
        n = 0;
        len_lim = (int'(len_reg) < URL_LEN_MAX) ? int'(len_reg) : URL_LEN_MAX;
        cnt_lim = (int'(urls_reg) < URL_COUNT_MAX) ? int'(urls_reg) : URL_COUNT_MAX;
        case (phase)
            SEEK_PATTERN:
            begin
                if (b == LINK_PATTERN[8*(6-int'(pat_pos)) +: 8])
                begin
                    if (pat_pos == 3'd6)
                    begin
                        pat_pos = 3'd0;
                        phase   = SEEK_QUOTE;
                    end
                    else
                    begin
                        pat_pos = pat_pos + 3'd1;
                    end
                end
                else
                begin
                    pat_pos = 3'd0;
                end
            end
            SEEK_QUOTE:
            begin
                phase   = (b == 8'h22) ? SEEK_H : SEEK_PATTERN;
                pat_pos = 3'd0;
            end
            SEEK_H:
            begin
                pat_pos = 3'd0;
                if (b != 8'h68)
                begin
                    phase = SEEK_PATTERN;
                end
                else
                begin
                    phase     = IN_URL;
                    url_bytes = 0;
                    dropped   = 1'b0;
                    link_live = links_taken < cnt_lim;
                    if (link_live)
                    begin
                        links_taken++;
                        if (url_bytes < len_lim)
                        begin
                            url_bytes++;
                            words[n] = url_word(b, 1'b0, 1'b0);
                            n++;
                        end
                        else
                        begin
                            dropped = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                if (b == 8'h22)
                begin
                    if (link_live)
                    begin
                        words[n] = url_word(8'h00, 1'b1, dropped);
                        n++;
                    end
                    phase     = SEEK_PATTERN;
                    pat_pos   = 3'd0;
                    link_live = 1'b0;
                end
                else if (link_live)
                begin
                    if (url_bytes < len_lim)
                    begin
                        url_bytes++;
                        words[n] = url_word(b, 1'b0, 1'b0);
                        n++;
                    end
                    else
                    begin
                        dropped = 1'b1;
                    end
                end
            end
        endcase
        if (page_last)
        begin
            if (phase == IN_URL && link_live)
            begin
                words[n] = url_word(8'h00, 1'b1, dropped);
                n++;
            end
            clear_page();
        end
        if (n > 0)
            words[n-1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            url_words.push_back(words[i]);
    endtask

    task automatic check_word();
        result_t got;
        result_t want;
        got.out_byte      = m_axis_tdata[BYTE_W-1:0];
        got.url_index     = m_axis_tdata[BYTE_W +: INDEX_W];
        got.url_end       = m_axis_tuser[0];
        got.url_truncated = m_axis_tuser[1];
        got.run_last      = m_axis_tlast;
        if (url_words.size() == 0)
        begin
            if (fail_count < 10)
                $display("%0t: unexpected word byte=%h end=%b index=%0d trunc=%b last=%b",
                         $realtime, got.out_byte, got.url_end, got.url_index,
                         got.url_truncated, got.run_last);
            fail_count++;
        end
        else
        begin
            want = url_words.pop_front();
            if (got !== want)
            begin
                if (fail_count < 10)
                    $display("%0t: word mismatch exp byte=%h end=%b index=%0d trunc=%b last=%b, got byte=%h end=%b index=%0d trunc=%b last=%b",
                             $realtime, want.out_byte, want.url_end, want.url_index,
                             want.url_truncated, want.run_last, got.out_byte, got.url_end,
                             got.url_index, got.url_truncated, got.run_last);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_page();
            len_reg  = MAX_URL_LEN_RESET;
            urls_reg = MAX_URLS_RESET;
            url_words.delete();
            fail_count    = 0;
            expected_left = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_MAX_URL_LEN)
                    len_reg = cfg_wdata[LEN_W-1:0];
                else if (cfg_index == REG_MAX_URLS)
                    urls_reg = cfg_wdata[COUNT_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                check_word();
            expected_left = url_words.size();
        end
    end

endmodule

@@ dv/href_link_extractor_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the href link extractor: clock, reset, page byte stimulus, limit writes
// and the verdict. Depends on hle_pkg, hle_checker and href_link_extractor_top.
module href_link_extractor_top_tb;
    import hle_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [M_TUSER_W-1:0]  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int                    fail_count;
    int                    expected_left;

    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    bytes_sent = 0;
    int                    len_now = 1000;

    always #5 clk = ~clk;

    href_link_extractor_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    hle_checker link_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic page_last);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= page_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic push_str(input string s, input logic page_last);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], page_last && (i == s.len() - 1));
    endtask

    function automatic logic [BYTE_W-1:0] body_byte();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(0, 255));
        while (b == CH_QUOTE);
        return b;
    endfunction

    // An unclosed link always carries at least one body byte, which takes the page end.
    task automatic push_link(input int body_len, input logic closed, input logic page_last);
        push_str("a href=\"h", 1'b0);
        for (int i = 0; i < body_len; i++)
            push_byte(body_byte(), page_last && !closed && (i == body_len - 1));
        if (closed)
            push_byte(CH_QUOTE, page_last);
    endtask

    task automatic random_chunk();
        int kind;
        int body_len;
        int lo;
        kind = $urandom_range(0, 99);
        if (kind < 55)
        begin
            if ($urandom_range(0, 9) == 0 && len_now <= 40)
            begin
                lo = (len_now > 0) ? len_now - 1 : 0;
                body_len = $urandom_range(lo, len_now + 2);
            end
            else
            begin
                body_len = $urandom_range(0, 6);
            end
            push_link(body_len, 1'b1, $urandom_range(0, 19) == 0);
        end
        else if (kind < 65)
        begin
            push_link($urandom_range(1, 5), 1'b0, 1'b1);
        end
        else if (kind < 80)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    push_str("a href=", 1'b0);
                    push_byte(body_byte(), 1'b0);
                end
                1:
                begin
                    push_str("a href=\"", 1'b0);
                    push_byte(CH_QUOTE, 1'b0);
                end
                2:
                begin
                    push_str("aa href=\"hz\"", 1'b0);
                end
                default:
                begin
                    push_str("a hre", 1'b0);
                    push_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
                end
            endcase
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                push_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end
    endtask

    task automatic drain(input int settle);
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (expected_left != 0);
        repeat (settle)
            @(posedge clk);
    endtask

    task automatic write_limits(input int len_val, input int urls_val);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_URL_LEN;
        cfg_wdata <= CFG_DATA_W'(len_val);
        @(posedge clk);
        cfg_index <= REG_MAX_URLS;
        cfg_wdata <= CFG_DATA_W'(urls_val);
        @(posedge clk);
        cfg_we    <= 1'b0;
        len_now = len_val;
    endtask

    initial
    begin
        int len_set[8];
        int urls_set[8];
        int target;
        len_set  = '{1000, 1023, 1, 0, 3, 2, 0, 5};
        urls_set = '{1000, 2047, 1, 0, 2, 1024, 0, 3};
        len_set[6]  = $urandom_range(1, 1023);
        urls_set[6] = $urandom_range(0, 2047);
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph > 0)
            begin
                drain(4);
                write_limits(len_set[ph], urls_set[ph]);
            end
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 55;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 55;
                end
                default:
                begin
                    send_idle_pct  = 26;
                    recv_stall_pct = 26;
                end
            endcase
            if (ph == 0)
            begin
                push_str("a href=\"h", 1'b0);
                push_byte(8'hff, 1'b0);
                push_byte(8'h00, 1'b0);
                push_byte(CH_QUOTE, 1'b0);
                push_str("a href=\"hz", 1'b1);
            end
            target = bytes_sent + 64;
            while (bytes_sent < target)
                random_chunk();
        end

        drain(10);
        if (fail_count == 0 && expected_left == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
